// ----- hw/rtl/tspa_pkg.sv -----
// Shared widths, codes and small types for the timestamp pair aligner.
// No dependencies; every other file of the block but tspa_ram imports this package.
`default_nettype none

package tspa_pkg;

    localparam int STAMP_W    = 62;
    localparam int HANDLE_W   = 16;
    localparam int REG_W      = 32;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int QUEUE_DEPTH_DEF = 16;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_MATCH   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EV_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FR_FULL = 2'd2;

    // Input item kinds.
    localparam logic KIND_EVENT = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_WINDOW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONSIST_LIM  = 1'b1;

    localparam logic [REG_W-1:0] MATCH_WINDOW_RST = 32'd25000000;
    localparam logic [REG_W-1:0] CONSIST_LIM_RST  = 32'd1000000;

    // Command from the sequencer to one queue pointer block.
    typedef struct packed {
        logic push;
        logic pop;
    } t_qcmd;

    // Occupancy flags from one queue pointer block.
    typedef struct packed {
        logic empty;
        logic full;
        logic last;
    } t_qflags;

endpackage

`default_nettype wire

// ----- hw/rtl/tspa_in_if.sv -----
// Input channel of the timestamp pair aligner: valid/ready plus one item.
// Depends on tspa_pkg for the field widths.
`default_nettype none

interface tspa_in_if import tspa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                kind;
    logic [STAMP_W-1:0]  header_stamp;
    logic [STAMP_W-1:0]  first_ref_stamp;
    logic [STAMP_W-1:0]  second_ref_stamp;
    logic [HANDLE_W-1:0] frame_handle;

    modport source (output valid, kind, header_stamp, first_ref_stamp,
                    second_ref_stamp, frame_handle, input ready);
    modport sink   (input valid, kind, header_stamp, first_ref_stamp,
                    second_ref_stamp, frame_handle, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tspa_out_if.sv -----
// Result channel of the timestamp pair aligner: valid/ready plus one item.
// Depends on tspa_pkg for the field widths.
`default_nettype none

interface tspa_out_if import tspa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [STAMP_W-1:0]  event_header_stamp;
    logic [STAMP_W-1:0]  event_first_ref;
    logic [STAMP_W-1:0]  event_second_ref;
    logic [STAMP_W-1:0]  frame_new_stamp;
    logic [HANDLE_W-1:0] matched_handle;

    modport source (output valid, status, event_header_stamp, event_first_ref,
                    event_second_ref, frame_new_stamp, matched_handle, input ready);
    modport sink   (input valid, status, event_header_stamp, event_first_ref,
                    event_second_ref, frame_new_stamp, matched_handle, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tspa_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module tspa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hw/rtl/tspa_qctl.sv -----
// Head pointer and fill count of one circular queue, with the tail slot.
// Depends on tspa_pkg for the command and flag structs.
`default_nettype none

module tspa_qctl import tspa_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_qcmd   i_cmd,
    output logic [AW-1:0] o_head,
    output logic [AW-1:0] o_tail,
    output t_qflags      o_flags
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_X   = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_CNT   = CW'(1);

    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [AW:0]   tail_sum;

    // Head plus count stays below twice the depth, so one subtract wraps it.
    always_comb begin
        tail_sum = (AW + 1)'(r_head) + (AW + 1)'(r_count);
        if (tail_sum >= DEPTH_X) begin
            tail_sum = tail_sum - DEPTH_X;
        end
    end

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_cmd.pop) begin
            n_head = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
        end
        if (i_cmd.push && !i_cmd.pop) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.pop && !i_cmd.push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    assign o_head        = r_head;
    assign o_tail        = tail_sum[AW-1:0];
    assign o_flags.empty = (r_count == '0);
    assign o_flags.full  = (r_count == FULL_CNT);
    assign o_flags.last  = (r_count == ONE_CNT);

endmodule

`default_nettype wire

// ----- hw/rtl/timestamp_pair_aligner_core.sv -----
// Top level of the timestamp pair aligner: sequencer, two queue memories,
// result register. Depends on tspa_pkg, tspa_in_if, tspa_out_if, tspa_ram, tspa_qctl.
//
//   Channel   Dir  Handshake          Payload
//   i_in      in   valid/ready        kind, header, two reference stamps, handle
//   o_out     out  valid/ready        status, three event stamps, new stamp, handle
//   i_cfg_*   in   write enable only  register index, 32-bit data
//
// In S_CHECK an item is stored, which ends its work when the other queue is empty,
// or discarded as inconsistent; a full-queue drop passes through S_EMIT to load
// the result. Each head comparison walks S_READ, S_CMP and S_DEC (memory read,
// subtract, decide), and a pair then passes through S_EMIT. The queue memories are
// not cleared by reset, which clears the pointers, counts, state, configuration
// registers and output valid flag. A result waits in the output register while the
// next item is taken; the sequencer stalls only when a second result is due.
`default_nettype none

module timestamp_pair_aligner_core import tspa_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [REG_W-1:0]     i_cfg_data,
    tspa_in_if.sink                   i_in,
    tspa_out_if.source                o_out
);

    localparam int AW   = $clog2(QUEUE_DEPTH);
    localparam int EV_W = 3 * STAMP_W;
    localparam int FR_W = STAMP_W + HANDLE_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_DEC   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0] r_state, n_state;

    logic [REG_W-1:0] r_window, r_limit;

    // The item being worked on.
    logic                r_kind;
    logic [STAMP_W-1:0]  r_hdr, r_r1, r_r2;
    logic [HANDLE_W-1:0] r_handle;

    logic [STAMP_W:0]    r_diff;

    // Pending result and output register.
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic [STAMP_W-1:0]  r_res_hdr, n_res_hdr;
    logic [STAMP_W-1:0]  r_res_r1, n_res_r1;
    logic [STAMP_W-1:0]  r_res_r2, n_res_r2;
    logic [HANDLE_W-1:0] r_res_handle, n_res_handle;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [STAMP_W-1:0]  r_out_hdr, r_out_r1, r_out_r2;
    logic [HANDLE_W-1:0] r_out_handle;

    t_qcmd   ev_cmd, fr_cmd;
    t_qflags ev_flags, fr_flags;
    logic [AW-1:0] ev_head, ev_tail, fr_head, fr_tail;

    logic            ev_re, fr_re;
    logic [EV_W-1:0] ev_q;
    logic [FR_W-1:0] fr_q;

    logic in_acc, out_free, load_out;

    logic [STAMP_W:0]   c_d12, c_d21;
    logic [STAMP_W-1:0] c_cons_abs;
    logic               c_consistent;

    logic [STAMP_W-1:0] es, fs, d_abs;
    logic               ev_older, is_match;

    tspa_qctl #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_ev_qctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (ev_cmd),
        .o_head  (ev_head),
        .o_tail  (ev_tail),
        .o_flags (ev_flags)
    );

    tspa_qctl #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_fr_qctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (fr_cmd),
        .o_head  (fr_head),
        .o_tail  (fr_tail),
        .o_flags (fr_flags)
    );

    tspa_ram #(.WIDTH(EV_W), .DEPTH(QUEUE_DEPTH), .AW(AW)) u_ev_ram (
        .i_clk   (i_clk),
        .i_we    (ev_cmd.push),
        .i_waddr (ev_tail),
        .i_wdata ({r_hdr, r_r1, r_r2}),
        .i_re    (ev_re),
        .i_raddr (ev_head),
        .o_rdata (ev_q)
    );

    tspa_ram #(.WIDTH(FR_W), .DEPTH(QUEUE_DEPTH), .AW(AW)) u_fr_ram (
        .i_clk   (i_clk),
        .i_we    (fr_cmd.push),
        .i_waddr (fr_tail),
        .i_wdata ({r_hdr, r_handle}),
        .i_re    (fr_re),
        .i_raddr (fr_head),
        .o_rdata (fr_q)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || o_out.ready;
    assign load_out   = (r_state == S_EMIT) && out_free;

    // Both differences in parallel, then one compare against the limit.
    always_comb begin
        c_d12 = {1'b0, r_r1} - {1'b0, r_r2};
        c_d21 = {1'b0, r_r2} - {1'b0, r_r1};
        c_cons_abs = c_d12[STAMP_W] ? c_d21[STAMP_W-1:0] : c_d12[STAMP_W-1:0];
        c_consistent = (c_cons_abs <= {{(STAMP_W - REG_W){1'b0}}, r_limit});
    end

    // The new item always sits on one side; the other side comes from memory.
    assign es = (r_kind == KIND_EVENT) ? r_hdr : ev_q[EV_W-1 -: STAMP_W];
    assign fs = (r_kind == KIND_FRAME) ? r_hdr : fr_q[FR_W-1 -: STAMP_W];

    always_comb begin
        d_abs = r_diff[STAMP_W] ? STAMP_W'(~r_diff[STAMP_W-1:0] + 1'b1)
                                : r_diff[STAMP_W-1:0];
        ev_older = r_diff[STAMP_W] || (r_diff[STAMP_W-1:0] == '0);
        is_match = (d_abs < {{(STAMP_W - REG_W){1'b0}}, r_window});
    end

    always_comb begin
        n_state      = r_state;
        ev_cmd       = '0;
        fr_cmd       = '0;
        ev_re        = 1'b0;
        fr_re        = 1'b0;
        n_res_status = r_res_status;
        n_res_hdr    = r_res_hdr;
        n_res_r1     = r_res_r1;
        n_res_r2     = r_res_r2;
        n_res_handle = r_res_handle;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_kind == KIND_EVENT && !c_consistent) begin
                    n_state = S_IDLE;
                end else if ((r_kind == KIND_EVENT && ev_flags.full) ||
                             (r_kind == KIND_FRAME && fr_flags.full)) begin
                    n_res_status = (r_kind == KIND_EVENT) ? ST_EV_FULL : ST_FR_FULL;
                    n_res_hdr    = '0;
                    n_res_r1     = '0;
                    n_res_r2     = '0;
                    n_res_handle = '0;
                    n_state      = S_EMIT;
                end else begin
                    ev_cmd.push = (r_kind == KIND_EVENT);
                    fr_cmd.push = (r_kind == KIND_FRAME);
                    if ((r_kind == KIND_EVENT && !fr_flags.empty) ||
                        (r_kind == KIND_FRAME && !ev_flags.empty)) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_READ: begin
                ev_re   = (r_kind == KIND_FRAME);
                fr_re   = (r_kind == KIND_EVENT);
                n_state = S_CMP;
            end
            S_CMP: begin
                n_state = S_DEC;
            end
            S_DEC: begin
                if (is_match) begin
                    ev_cmd.pop   = 1'b1;
                    fr_cmd.pop   = 1'b1;
                    n_res_status = ST_MATCH;
                    if (r_kind == KIND_EVENT) begin
                        n_res_hdr    = r_hdr;
                        n_res_r1     = r_r1;
                        n_res_r2     = r_r2;
                        n_res_handle = fr_q[HANDLE_W-1:0];
                    end else begin
                        n_res_hdr    = ev_q[EV_W-1 -: STAMP_W];
                        n_res_r1     = ev_q[2*STAMP_W-1 -: STAMP_W];
                        n_res_r2     = ev_q[STAMP_W-1:0];
                        n_res_handle = r_handle;
                    end
                    n_state = S_EMIT;
                end else if (ev_older) begin
                    ev_cmd.pop = 1'b1;
                    // Popping the new event ends the walk; a queued event
                    // ends it only when it was the last one.
                    n_state = (r_kind == KIND_EVENT || ev_flags.last) ? S_IDLE : S_READ;
                end else begin
                    fr_cmd.pop = 1'b1;
                    n_state = (r_kind == KIND_FRAME || fr_flags.last) ? S_IDLE : S_READ;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_window    <= MATCH_WINDOW_RST;
            r_limit     <= CONSIST_LIM_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MATCH_WINDOW: r_window <= i_cfg_data;
                    CFG_CONSIST_LIM:  r_limit  <= i_cfg_data;
                    default:          r_window <= r_window;
                endcase
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind   <= i_in.kind;
            r_hdr    <= i_in.header_stamp;
            r_r1     <= i_in.first_ref_stamp;
            r_r2     <= i_in.second_ref_stamp;
            r_handle <= i_in.frame_handle;
        end
        if (r_state == S_CMP) begin
            r_diff <= {1'b0, es} - {1'b0, fs};
        end
        r_res_status <= n_res_status;
        r_res_hdr    <= n_res_hdr;
        r_res_r1     <= n_res_r1;
        r_res_r2     <= n_res_r2;
        r_res_handle <= n_res_handle;
        if (load_out) begin
            r_out_status <= r_res_status;
            r_out_hdr    <= r_res_hdr;
            r_out_r1     <= r_res_r1;
            r_out_r2     <= r_res_r2;
            r_out_handle <= r_res_handle;
        end
    end

    assign o_out.valid              = r_out_valid;
    assign o_out.status             = r_out_status;
    assign o_out.event_header_stamp = r_out_hdr;
    assign o_out.event_first_ref    = r_out_r1;
    assign o_out.event_second_ref   = r_out_r2;
    assign o_out.frame_new_stamp    = r_out_r1;
    assign o_out.matched_handle     = r_out_handle;

endmodule

`default_nettype wire

// ----- sim/tb_timestamp_pair_aligner_core.sv -----
// Self-checking testbench for timestamp_pair_aligner_core: drives events and frames
// with random bursts and output stalls, and predicts every result with a queue model.
// Depends on tspa_pkg, tspa_in_if, tspa_out_if and the core itself.
`timescale 1ns / 1ps

module tb_timestamp_pair_aligner_core;
    import tspa_pkg::*;

    localparam int STALL_LIMIT = 3000;  // cycles with no item moving on either channel
    localparam int SETTLE      = 120;   // longest item latency with margin
    localparam int NUM_PHASES  = 6;
    localparam int PHASE_ITEMS = 125;

    typedef logic [STAMP_W-1:0] t_stamp;

    typedef struct packed {
        logic                kind;
        t_stamp              header_stamp;
        t_stamp              first_ref;
        t_stamp              second_ref;
        logic [HANDLE_W-1:0] handle;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        t_stamp              ev_header;
        t_stamp              ev_first;
        t_stamp              ev_second;
        t_stamp              new_stamp;
        logic [HANDLE_W-1:0] handle;
    } t_pair_result;

    typedef struct packed {
        t_stamp header_stamp;
        t_stamp first_ref;
        t_stamp second_ref;
    } t_ev_entry;

    typedef struct packed {
        t_stamp              header_stamp;
        logic [HANDLE_W-1:0] handle;
    } t_fr_entry;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_CHOKE} t_rx_mode;

    // Mirrors both queues and the registers; holds the results still owed by the core.
    class pairing_tracker;
        logic [REG_W-1:0] window_ns;
        logic [REG_W-1:0] limit_ns;
        t_ev_entry        ev_q[$];
        t_fr_entry        fr_q[$];
        t_pair_result     owed[$];
        int n_pairs, n_ev_full, n_fr_full, n_inconsistent, n_errors;

        function new();
            window_ns = MATCH_WINDOW_RST;
            limit_ns  = CONSIST_LIM_RST;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] value);
            case (idx)
                CFG_MATCH_WINDOW: window_ns = value;
                CFG_CONSIST_LIM:  limit_ns = value;
                default: ;
            endcase
        endfunction

        function t_stamp stamp_dist(t_stamp a, t_stamp b);
            return (a > b) ? a - b : b - a;
        endfunction

        // Returns 0 when the core silently ignores the item.
        function bit take_item(t_in_item it);
            t_pair_result r;
            t_ev_entry    e;
            t_fr_entry    f;
            r = '0;
            if (it.kind == KIND_EVENT) begin
                if (stamp_dist(it.first_ref, it.second_ref) > limit_ns) begin
                    n_inconsistent++;
                    return 0;
                end
                if (ev_q.size() >= QUEUE_DEPTH_DEF) begin
                    r.status = ST_EV_FULL;
                    owed.insert(owed.size(), r);
                    n_ev_full++;
                    return 1;
                end
                ev_q.insert(ev_q.size(),
                            t_ev_entry'{it.header_stamp, it.first_ref, it.second_ref});
            end else begin
                if (fr_q.size() >= QUEUE_DEPTH_DEF) begin
                    r.status = ST_FR_FULL;
                    owed.insert(owed.size(), r);
                    n_fr_full++;
                    return 1;
                end
                fr_q.insert(fr_q.size(), t_fr_entry'{it.header_stamp, it.handle});
            end
            while (ev_q.size() > 0 && fr_q.size() > 0) begin
                e = ev_q[0];
                f = fr_q[0];
                if (stamp_dist(e.header_stamp, f.header_stamp) < window_ns) begin
                    r.status    = ST_MATCH;
                    r.ev_header = e.header_stamp;
                    r.ev_first  = e.first_ref;
                    r.ev_second = e.second_ref;
                    r.new_stamp = e.first_ref;
                    r.handle    = f.handle;
                    owed.insert(owed.size(), r);
                    void'(ev_q.pop_front());
                    void'(fr_q.pop_front());
                    n_pairs++;
                    return 1;
                end
                // The stale head goes; on a tie the event is the one dropped.
                if (e.header_stamp <= f.header_stamp)
                    void'(ev_q.pop_front());
                else
                    void'(fr_q.pop_front());
            end
            return 1;
        endfunction

        function void check_result(t_pair_result got);
            t_pair_result want;
            if (owed.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("ERROR %0t: result with none pending: st=%0d hdr=%h h=%h",
                             $realtime, got.status, got.ev_header, got.handle);
                return;
            end
            want = owed.pop_front();
            if (want.status != got.status || want.ev_header != got.ev_header ||
                want.ev_first != got.ev_first || want.ev_second != got.ev_second ||
                want.new_stamp != got.new_stamp || want.handle != got.handle) begin
                n_errors++;
                if (n_errors <= 10) begin
                    $display("ERROR %0t: exp st=%0d hdr=%h r1=%h r2=%h new=%h h=%h",
                             $realtime, want.status, want.ev_header, want.ev_first,
                             want.ev_second, want.new_stamp, want.handle);
                    $display("       got st=%0d hdr=%h r1=%h r2=%h new=%h h=%h",
                             got.status, got.ev_header, got.ev_first,
                             got.ev_second, got.new_stamp, got.handle);
                end
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [REG_W-1:0]     cfg_data;

    tspa_in_if  in_ch();
    tspa_out_if out_ch();

    timestamp_pair_aligner_core DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    pairing_tracker tracker = new();

    t_stamp   stamp_now;
    int       burst_left;
    bit       steady;
    int       items_used;
    int       settings_run;
    int       idle_cycles;
    t_rx_mode rx_mode;
    int       rx_left;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Result side: stall pattern that switches between open, random and choked stretches.
    always @(negedge clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 2));
            rx_left = $urandom_range(8, 64);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            RX_OPEN:  out_ch.ready = 1'b1;
            RX_COIN:  out_ch.ready = 1'($urandom_range(0, 1));
            default:  out_ch.ready = ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready)
            tracker.check_result('{out_ch.status, out_ch.event_header_stamp,
                                   out_ch.event_first_ref, out_ch.event_second_ref,
                                   out_ch.frame_new_stamp, out_ch.matched_handle});
    end

    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == STALL_LIMIT) begin
            $display("no progress for %0d cycles", STALL_LIMIT);
            $display("timestamp_pair_aligner_core test failed");
            $finish;
        end
    end

    function automatic t_stamp wide_rand();
        return t_stamp'({$urandom, $urandom});
    endfunction

    function automatic t_in_item mk(logic kind, t_stamp hdr, t_stamp r1, t_stamp r2,
                                    logic [HANDLE_W-1:0] handle);
        return '{kind, hdr, r1, r2, handle};
    endfunction

    function automatic t_in_item make_event(t_stamp hdr, bit consistent);
        t_stamp span;
        t_stamp d;
        t_stamp r1;
        t_stamp r2;
        span = t_stamp'(tracker.limit_ns) + t_stamp'(1);
        if (consistent)
            d = ($urandom_range(0, 7) == 0) ? span - t_stamp'(1) : wide_rand() % span;
        else
            d = ($urandom_range(0, 3) == 0) ? span
                                            : span + t_stamp'($urandom_range(0, 65535));
        r1 = hdr + t_stamp'($urandom_range(0, 1 << 20));
        r2 = $urandom_range(0, 1) ? r1 + d : r1 - d;
        return mk(KIND_EVENT, hdr, r1, r2, HANDLE_W'($urandom));
    endfunction

    function automatic t_in_item make_frame(t_stamp hdr);
        return mk(KIND_FRAME, hdr, wide_rand(), wide_rand(), HANDLE_W'($urandom));
    endfunction

    // Frame stamp near an event stamp, inside or outside the pairing window.
    function automatic t_stamp near_stamp(t_stamp base, bit in_window);
        t_stamp w;
        t_stamp m;
        w = t_stamp'(tracker.window_ns);
        if (in_window)
            m = (w == '0) ? '0 : ($urandom_range(0, 7) == 0) ? w - t_stamp'(1)
                                                              : wide_rand() % w;
        else
            m = ($urandom_range(0, 7) == 0) ? w : w + t_stamp'($urandom_range(0, 65535));
        return $urandom_range(0, 1) ? base + m : base - m;
    endfunction

    task automatic send_item(t_in_item it);
        int gap;
        if (burst_left == 0) begin
            gap = steady ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                @(negedge clk);
                in_ch.valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge clk);
        in_ch.kind             = it.kind;
        in_ch.header_stamp     = it.header_stamp;
        in_ch.first_ref_stamp  = it.first_ref;
        in_ch.second_ref_stamp = it.second_ref;
        in_ch.frame_handle     = it.handle;
        in_ch.valid            = 1'b1;
        do @(posedge clk); while (!in_ch.ready);
        void'(tracker.take_item(it));
        items_used++;
        burst_left--;
    endtask

    // Leaves the core idle: input low, every result delivered, queue work finished.
    task automatic drain();
        @(negedge clk);
        in_ch.valid = 1'b0;
        burst_left = 0;
        while (tracker.owed.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] value);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
        tracker.set_reg(idx, value);
    endtask

    task automatic run_directed();
        t_stamp top;
        top = '1;
        send_item(mk(KIND_EVENT, '0, '0, '0, 16'h1234));
        send_item(mk(KIND_FRAME, '0, '0, '0, 16'h0000));
        // Reference stamps exactly at the consistency limit, header stamps at or near full scale.
        send_item(mk(KIND_EVENT, top, top, top - 62'd1000000, 16'h0));
        send_item(mk(KIND_FRAME, top - 62'd24999999, top, top, 16'hFFFF));
        send_item(mk(KIND_EVENT, 62'd5, 62'd0, 62'd1000001, 16'h0));
        // A difference equal to the window does not pair; the older frame goes.
        send_item(mk(KIND_FRAME, 62'd1000, '0, '0, 16'h0001));
        send_item(mk(KIND_EVENT, 62'd25001000, 62'd10, 62'd10, 16'h0));
        send_item(mk(KIND_FRAME, 62'd25001005, '0, '0, 16'h0002));
        // Two stale events in front of a frame, then a late event that pairs.
        send_item(mk(KIND_EVENT, 62'd500, 62'd500, 62'd500, 16'h0));
        send_item(mk(KIND_EVENT, 62'd600, 62'd600, 62'd601, 16'h0));
        send_item(mk(KIND_FRAME, 62'd25000700, '0, '0, 16'h0003));
        send_item(mk(KIND_EVENT, 62'd25000700, 62'd77, 62'd78, 16'h0));
        // Fill the frame queue and overflow it once.
        for (int k = 0; k < QUEUE_DEPTH_DEF + 1; k++)
            send_item(mk(KIND_FRAME, 62'd2000 + k, '0, '0, HANDLE_W'(k)));
    endtask

    task automatic run_random(int target);
        int       goal;
        int       pick;
        int       n;
        int       order;
        bit       flood_frames;
        t_in_item evs[$];
        t_in_item frs[$];
        goal = items_used + target;
        while (items_used < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                n = $urandom_range(1, 4);
                evs.delete();
                frs.delete();
                for (int i = 0; i < n; i++) begin
                    stamp_now = stamp_now + (t_stamp'(tracker.window_ns) << 1) +
                                t_stamp'($urandom_range(0, 1 << 20));
                    evs.insert(evs.size(),
                               make_event(stamp_now, $urandom_range(0, 9) != 0));
                    frs.insert(frs.size(),
                               make_frame(near_stamp(stamp_now, $urandom_range(0, 7) != 0)));
                end
                order = $urandom_range(0, 2);
                if (order == 2) begin
                    for (int i = 0; i < n; i++) begin
                        send_item(evs[i]);
                        send_item(frs[i]);
                    end
                end else begin
                    foreach (evs[i]) send_item(order == 0 ? evs[i] : frs[i]);
                    foreach (frs[i]) send_item(order == 0 ? frs[i] : evs[i]);
                end
            end else if (pick < 70) begin
                stamp_now = stamp_now + t_stamp'($urandom_range(0, 1 << 20));
                if ($urandom_range(0, 1))
                    send_item(make_event(stamp_now, 1'b1));
                else
                    send_item(make_frame(near_stamp(stamp_now, 1'b0)));
            end else if (pick < 78) begin
                send_item(make_event(stamp_now, 1'b0));
            end else if (pick < 85) begin
                flood_frames = 1'($urandom_range(0, 1));
                n = $urandom_range(14, 20);
                for (int i = 0; i < n; i++) begin
                    stamp_now = stamp_now + t_stamp'($urandom_range(0, 1000));
                    send_item(flood_frames ? make_frame(stamp_now)
                                           : make_event(stamp_now, 1'b1));
                end
            end else begin
                send_item(mk(1'($urandom_range(0, 1)), wide_rand(), wide_rand(),
                             wide_rand(), HANDLE_W'($urandom)));
            end
        end
    endtask

    initial begin
        logic [REG_W-1:0] win_set[NUM_PHASES];
        logic [REG_W-1:0] lim_set[NUM_PHASES];
        win_set = '{32'd25000000, 32'd0, 32'hFFFFFFFF, 32'd1000, 32'd0, 32'd25000000};
        lim_set = '{32'd1000000, 32'd0, 32'hFFFFFFFF, 32'd50, 32'd0, 32'd1000000};
        win_set[4] = $urandom_range(1000, 50000000);
        lim_set[4] = $urandom;

        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_idx                = CFG_MATCH_WINDOW;
        cfg_data               = '0;
        in_ch.valid            = 1'b0;
        in_ch.kind             = KIND_EVENT;
        in_ch.header_stamp     = '0;
        in_ch.first_ref_stamp  = '0;
        in_ch.second_ref_stamp = '0;
        in_ch.frame_handle     = '0;
        out_ch.ready           = 1'b0;
        rx_mode                = RX_OPEN;
        rx_left                = 0;
        idle_cycles            = 0;
        burst_left             = 0;
        items_used             = 0;
        settings_run           = 0;
        stamp_now              = wide_rand();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_reg(CFG_MATCH_WINDOW, win_set[p]);
            write_reg(CFG_CONSIST_LIM, lim_set[p]);
            settings_run++;
            steady = (p == 2);
            if (p == 0)
                run_directed();
            run_random(PHASE_ITEMS);
            drain();
        end

        if (tracker.owed.size() != 0) begin
            $display("ERROR: %0d results never arrived", tracker.owed.size());
            tracker.n_errors += tracker.owed.size();
        end
        $display("covered %0d items: %0d pairs, %0d event-queue drops, %0d frame-queue drops",
                 items_used, tracker.n_pairs, tracker.n_ev_full, tracker.n_fr_full);
        $display("%0d inconsistent events ignored, %0d register settings, %0d mismatches",
                 tracker.n_inconsistent, settings_run, tracker.n_errors);
        if (tracker.n_errors == 0)
            $display("timestamp_pair_aligner_core test passed");
        else
            $display("timestamp_pair_aligner_core test failed");
        $finish;
    end

endmodule
